FILE: rtl/fbpa_pkg.sv
// shared types and constants for the fixed block pool allocator
package fbpa_pkg;

	// fixed field widths
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// request command codes
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOT_USED = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	// controller states
	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// request payload
	typedef struct packed {
		cmd_t               command;
		logic [INDEX_W-1:0] block_index;
	} req_t;

	// response payload
	typedef struct packed {
		logic               success;
		logic [INDEX_W-1:0] granted_index;
		status_t            status_code;
	} rsp_t;

endpackage

FILE: rtl/fbpa_if.sv
// valid/ready channel interfaces for requests and responses

interface fbpa_req_if;
	import fbpa_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fbpa_rsp_if;
	import fbpa_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fbpa_ram.sv
// generic single write port ram with registered read
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/fixed_block_pool_allocator_unit.sv
// fixed block pool allocator: lifo free list and used marks held in rams
//
// Usage:
//   req channel (sink): command CMD_ALLOC takes the top free block,
//     command CMD_FREE returns block_index to the pool.
//   rsp channel (source): one response per request with success,
//     granted_index (zero unless an allocation succeeded) and status_code.
//   Each request runs through an accept step and an execute step: the accept step
//   issues the reads of the free stack ram and the used mark ram, the execute
//   step checks the marks, writes both rams back and loads the response register.
//   A new request is accepted only after that, once the unit is back in idle,
//   so a request is not taken while the previous one is still in the rams.
//   The response is registered and becomes valid once the execute step loads it.
//   At reset every block is free and allocations hand out indices in
//   ascending order; per-entry written flags stand in for the ram contents
//   until an entry is first written, so no clearing pass is needed.
//   While the response register is full and not taken, a request in flight
//   waits in the execute state with its read data held, and no new request
//   is accepted.
module fixed_block_pool_allocator_unit #(
	parameter int POOL_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	fbpa_req_if.sink    req,
	fbpa_rsp_if.source  rsp
);
	import fbpa_pkg::*;

	localparam int AW = $clog2(POOL_BLOCKS);
	localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(POOL_BLOCKS - 1);
	localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(POOL_BLOCKS);

	fsm_t state_q, state_d;

	logic                  accept;
	logic                  do_step;
	logic [COUNT_W-1:0]    free_count_q;
	logic [COUNT_W-1:0]    top_cnt;
	logic [AW-1:0]         top_addr;
	logic [AW-1:0]         idx_addr;

	// request held over the execute state
	cmd_t                  cmd_s1;
	logic [INDEX_W-1:0]    idx_s1;
	logic [AW-1:0]         top_addr_s1;
	logic                  stk_vld_s1;
	logic                  use_vld_s1;

	// written flags for both rams
	logic [POOL_BLOCKS-1:0] stk_wr_q;
	logic [POOL_BLOCKS-1:0] use_wr_q;

	// ram ports
	logic                  stk_we;
	logic [AW-1:0]         stk_waddr;
	logic [INDEX_W-1:0]    stk_wdata;
	logic [INDEX_W-1:0]    stk_rdata;
	logic                  use_we;
	logic [AW-1:0]         use_waddr;
	logic                  use_wdata;
	logic                  use_rdata;

	// execute results
	logic [INDEX_W-1:0]    top_blk;
	logic                  blk_used;
	logic                  alloc_ok;
	logic                  free_ok;
	rsp_t                  rsp_d;

	logic                  out_valid_q;
	rsp_t                  out_data_q;

	assign top_cnt  = free_count_q - COUNT_W'(1);
	assign top_addr = top_cnt[AW-1:0];
	assign idx_addr = req.data.block_index[AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req.valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready = 1'b0;
		do_step   = 1'b0;
		unique case (state_q)
			FSM_IDLE: req.ready = 1'b1;
			FSM_EXEC: do_step = !out_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				do_step   = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture request and written flags of the addresses being read
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= req.data.command;
			idx_s1      <= req.data.block_index;
			top_addr_s1 <= top_addr;
			stk_vld_s1  <= stk_wr_q[top_addr];
			use_vld_s1  <= use_wr_q[idx_addr];
		end
	end

	// free stack and used marks
	fbpa_ram #(.WIDTH(INDEX_W), .DEPTH(POOL_BLOCKS)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (top_addr),
		.rdata (stk_rdata)
	);

	fbpa_ram #(.WIDTH(1), .DEPTH(POOL_BLOCKS)) u_used_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (use_waddr),
		.wdata (use_wdata),
		.re    (accept),
		.raddr (idx_addr),
		.rdata (use_rdata)
	);

	// unwritten stack entries hold the descending reset order
	assign top_blk  = stk_vld_s1 ? stk_rdata : LAST_IDX - INDEX_W'(top_addr_s1);
	assign blk_used = use_vld_s1 && use_rdata;

	// decide the operation and its response
	always_comb begin
		alloc_ok          = 1'b0;
		free_ok           = 1'b0;
		rsp_d.success     = 1'b0;
		rsp_d.granted_index = '0;
		rsp_d.status_code = ST_OK;
		if (cmd_s1 == CMD_ALLOC) begin
			if (free_count_q == '0) begin
				rsp_d.status_code = ST_EMPTY;
			end else begin
				alloc_ok            = 1'b1;
				rsp_d.success       = 1'b1;
				rsp_d.granted_index = top_blk;
			end
		end else begin
			if ({1'b0, idx_s1} >= FULL_CNT) begin
				rsp_d.status_code = ST_RANGE;
			end else if (!blk_used || free_count_q >= FULL_CNT) begin
				rsp_d.status_code = ST_NOT_USED;
			end else begin
				free_ok       = 1'b1;
				rsp_d.success = 1'b1;
			end
		end
	end

	// write back: allocation marks the block, release clears it and pushes
	always_comb begin
		stk_we    = do_step && free_ok;
		stk_waddr = free_count_q[AW-1:0];
		stk_wdata = idx_s1;
		use_we    = do_step && (alloc_ok || free_ok);
		use_waddr = alloc_ok ? top_blk[AW-1:0] : idx_s1[AW-1:0];
		use_wdata = alloc_ok;
	end

	// free count and written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= FULL_CNT;
			stk_wr_q     <= '0;
			use_wr_q     <= '0;
		end else if (do_step) begin
			if (alloc_ok) begin
				free_count_q <= top_cnt;
			end else if (free_ok) begin
				free_count_q <= free_count_q + COUNT_W'(1);
			end
			if (stk_we) begin
				stk_wr_q[stk_waddr] <= 1'b1;
			end
			if (use_we) begin
				use_wr_q[use_waddr] <= 1'b1;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_step) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			out_data_q <= rsp_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

endmodule
